FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must hold in the cycle after its trigger
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

FILE: src/cgpg_pkg.sv
// Package: widths, types and CORDIC step angles for the conic gradient generator
package cgpg_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int AW            = $clog2(PALETTE_DEPTH);
    localparam int COORD_BITS    = 11;
    localparam int ANGLE_BITS    = 16;
    localparam int NSTEP         = ANGLE_BITS;
    localparam int DW            = COORD_BITS + 2;
    localparam int PRE_SHIFT     = 24;
    localparam int XW            = DW + PRE_SHIFT + 3;
    localparam int ZW            = ANGLE_BITS + 4;
    localparam int PW            = ZW + 11;

    localparam logic [2:0] REG_CX     = 3'd0;
    localparam logic [2:0] REG_CY     = 3'd1;
    localparam logic [2:0] REG_NENT   = 3'd2;
    localparam logic [2:0] REG_MIRROR = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic                  zero;
        logic [7:0]            idx;
        logic [31:0]           colour;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
    } side_t;

    typedef struct packed {
        logic [31:0]           colour;
        logic [7:0]            slot;
        logic [COORD_BITS-1:0] oy;
        logic [COORD_BITS-1:0] ox;
    } result_t;

    // atan(2^-i) in units of 2^-16 turn, rounded half up
    function automatic logic signed [ZW-1:0] step_angle(input int i);
        logic [15:0] a;
        case (i)
            0:       a = 16'd8192;
            1:       a = 16'd4836;
            2:       a = 16'd2555;
            3:       a = 16'd1297;
            4:       a = 16'd651;
            5:       a = 16'd326;
            6:       a = 16'd163;
            7:       a = 16'd81;
            8:       a = 16'd41;
            9:       a = 16'd20;
            10:      a = 16'd10;
            11:      a = 16'd5;
            12:      a = 16'd3;
            13:      a = 16'd1;
            14:      a = 16'd1;
            default: a = 16'd0;
        endcase
        return $signed({{(ZW-16){1'b0}}, a});
    endfunction

endpackage

FILE: src/conic_gradient_pixel_gen_top.sv
// Top level: conic gradient generator with palette memory and output skid
//
// Channel   Signals                          Role
// s_axis    s_tvalid s_tready s_tdata s_tuser  palette loads and pixels in
// m_axis    m_tvalid m_tready m_tdata          colored pixels out
// cfg       cfg_we cfg_addr cfg_data           register writes
//
// One item per cycle while the skid register is empty; pixels pass the input
// register, the 16-stage CORDIC, the scale stages and the palette read register.
// Reset clears control only; palette contents are undefined until loaded.
// A stalled result moves to a skid register; s_tready drops only while it is full.
module conic_gradient_pixel_gen_top
    import cgpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entry_index, entry_colour, pixel_x, pixel_y
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_x, out_y, palette_slot, colour
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_data
);

`include "assert_macros.svh"

    logic [11:0] cx_reg;
    logic [11:0] cy_reg;
    logic [8:0]  nent_reg;
    logic        mirror_reg;
    logic [11:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= 12'd2048;
            cy_reg     <= 12'd2048;
            nent_reg   <= 9'd256;
            mirror_reg <= 1'b0;
            width_reg  <= 12'd2048;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CX:     cx_reg     <= cfg_data;
                REG_CY:     cy_reg     <= cfg_data;
                REG_NENT:   nent_reg   <= cfg_data[8:0];
                REG_MIRROR: mirror_reg <= cfg_data[0];
                REG_WIDTH:  width_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic [8:0] n_eff;
    always_comb
    begin
        if (nent_reg < 9'd2)
        begin
            n_eff = 9'd2;
        end
        else if (nent_reg > 9'(PALETTE_DEPTH))
        begin
            n_eff = 9'(PALETTE_DEPTH);
        end
        else
        begin
            n_eff = nent_reg;
        end
    end

    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // input register
    logic  in_valid_reg;
    side_t in_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_side_reg.mode   <= s_tuser;
            in_side_reg.zero   <= 1'b0;
            in_side_reg.idx    <= s_tdata[7:0];
            in_side_reg.colour <= s_tdata[39:8];
            in_side_reg.px     <= s_tdata[50:40];
            in_side_reg.py     <= s_tdata[61:51];
        end
    end

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    assign dx = $signed({1'b0, in_side_reg.px, 1'b0}) - $signed({1'b0, cx_reg});
    assign dy = $signed({1'b0, in_side_reg.py, 1'b0}) - $signed({1'b0, cy_reg});

    logic                 c_valid;
    side_t                c_side;
    logic signed [ZW-1:0] c_z;

    cgpg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_side   (in_side_reg),
        .dx        (dx),
        .dy        (dy),
        .out_valid (c_valid),
        .out_side  (c_side),
        .out_z     (c_z)
    );

    // scale stage 1: multiply by (n - 1)
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);

    logic                 mul_valid_reg;
    side_t                mul_side_reg;
    logic signed [PW-1:0] mul_reg;
    logic signed [ZW-1:0] a_ang;
    assign a_ang = c_z + QUARTER;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_side_reg <= c_side;
            mul_reg      <= PW'(a_ang) * $signed({{(PW-9){1'b0}}, n_eff - 9'd1});
        end
    end

    // scale stage 2: offset, round, reduce
    logic signed [PW-1:0] prod;
    logic [PW-1:0]        prod_c;
    logic [PW-ANGLE_BITS-1:0] v0;
    logic [PW-ANGLE_BITS-1:0] v1;
    logic [PW-ANGLE_BITS-1:0] n_w;
    logic [7:0]           slot;
    logic [11:0]          mir;

    always_comb
    begin
        prod   = mul_reg + ($signed({{(PW-9){1'b0}}, n_eff}) <<< ANGLE_BITS)
               + (PW'(1) <<< (ANGLE_BITS - 1));
        prod_c = prod[PW-1] ? '0 : prod;
        v0     = prod_c[PW-1:ANGLE_BITS];
        n_w    = (PW-ANGLE_BITS)'(n_eff);
        v1     = (v0 >= n_w) ? v0 - n_w : v0;
        if (v1 >= n_w)
        begin
            v1 = n_w - 1'b1;
        end
        slot   = v1[7:0];
        mir    = width_reg - 12'd1 - {1'b0, mul_side_reg.px};
    end

    logic    r_valid_reg;
    side_t   r_side_reg;
    logic [7:0] r_slot_reg;
    logic [COORD_BITS-1:0] r_ox_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_side_reg <= mul_side_reg;
            r_slot_reg <= slot;
            r_ox_reg   <= mirror_reg ? mir[COORD_BITS-1:0] : mul_side_reg.px;
        end
    end

    // palette memory: loads and lookups in item order
    logic [31:0] palette [0:PALETTE_DEPTH-1];
    logic        l_valid_reg;
    result_t     l_reg;

    always_ff @(posedge clk)
    begin
        if (en && r_valid_reg && (r_side_reg.mode == MODE_LOAD))
        begin
            palette[r_side_reg.idx[AW-1:0]] <= r_side_reg.colour;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg.colour <= palette[r_slot_reg[AW-1:0]];
            l_reg.slot   <= r_slot_reg;
            l_reg.oy     <= r_side_reg.py;
            l_reg.ox     <= r_ox_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            l_valid_reg <= r_valid_reg && (r_side_reg.mode == MODE_PIXEL);
        end
    end

    // output skid
    result_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (l_valid_reg && !m_tready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_reg <= l_reg;
        end
    end

    assign m_tvalid = skid_valid_reg || l_valid_reg;
    assign m_tdata  = {2'b00, (skid_valid_reg ? skid_reg : l_reg)};

    `ASSERT_CLK(a_skid_shown, !skid_valid_reg || m_tvalid, "skid entry not presented")
    `ASSERT_NEXT(a_skid_hold, skid_valid_reg && !m_tready, skid_valid_reg && $stable(skid_reg),
        "skid entry lost while stalled")
    `ASSERT_CLK(a_slot_range, !l_valid_reg || ({1'b0, l_reg.slot} < n_eff),
        "palette slot out of range")

endmodule

FILE: src/cgpg_cordic.sv
// Pipelined vectoring CORDIC: offset vector to angle in fractions of a turn
module cgpg_cordic
    import cgpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  side_t                in_side,
    input  logic signed [DW-1:0] dx,
    input  logic signed [DW-1:0] dy,
    output logic                 out_valid,
    output side_t                out_side,
    output logic signed [ZW-1:0] out_z
);

    localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (ANGLE_BITS - 1);

    logic                 valid_reg [0:NSTEP];
    side_t                side_reg  [0:NSTEP];
    logic signed [XW-1:0] x_reg     [0:NSTEP];
    logic signed [XW-1:0] y_reg     [0:NSTEP];
    logic signed [ZW-1:0] z_reg     [0:NSTEP];

    logic signed [DW-1:0] dxn;
    logic signed [DW-1:0] dyn;
    logic signed [ZW-1:0] z_init;
    side_t                side_next;

    always_comb
    begin
        dxn    = dx[DW-1] ? -dx : dx;
        dyn    = dx[DW-1] ? -dy : dy;
        z_init = '0;
        if (dx[DW-1])
        begin
            z_init = dy[DW-1] ? -HALF : HALF;
        end
        side_next      = in_side;
        side_next.zero = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            x_reg[0]    <= XW'(dxn) <<< PRE_SHIFT;
            y_reg[0]    <= XW'(dyn) <<< PRE_SHIFT;
            z_reg[0]    <= z_init;
        end
    end

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (!y_reg[i][XW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + step_angle(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - step_angle(i);
                end
            end
        end
    end

    assign out_valid = valid_reg[NSTEP];
    assign out_side  = side_reg[NSTEP];
    assign out_z     = side_reg[NSTEP].zero ? '0 : z_reg[NSTEP];

endmodule
